[rtl/core/median_threshold_binarizer_assert.svh]
// ----------------------------------------------------------------------------
// Median threshold binarizer assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_THRESHOLD_BINARIZER_ASSERT_SVH
`define MEDIAN_THRESHOLD_BINARIZER_ASSERT_SVH

// Same-cycle implication, disabled while the given reset is high.
`define MTB_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while the given reset is high.
`define MTB_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/core/mtb_pkg.sv]
// ----------------------------------------------------------------------------
// Median threshold binarizer package
// Shared widths, codes, queue entry and status types, and the back-end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtb_pkg;

   // Histogram geometry and counter widths.
   localparam int GREY_BINS = 256;
   localparam int BIN_W     = $clog2(GREY_BINS);
   localparam int CNT_W     = 21;
   localparam int RUN_W     = CNT_W + 1;
   localparam int THR_W     = 9;
   localparam int PIX_W     = 8;

   // Frame limit at which every count saturates.
   localparam logic [CNT_W-1:0] MAX_FRAME_PIXELS = CNT_W'(1048576);

   // Division of the channel sum by three: multiply by 683 and drop 11 bits,
   // exact for every sum below 2048.
   localparam int SUM_W      = PIX_W + 2;
   localparam int PROD_W     = 2 * SUM_W;
   localparam int DIV3_SHIFT = 11;
   localparam logic [SUM_W-1:0] DIV3_MUL = SUM_W'(683);

   // Output levels of a classified pixel.
   localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;
   localparam logic [PIX_W-1:0] BLACK_LEVEL = 8'd0;

   // Item codes.
   localparam logic OP_ACCUM    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic             op;
      logic [BIN_W-1:0] grey;
      logic             frame_end;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_SCAN_START,
      BK_SCAN,
      BK_REPORT
   } back_state_type;

   // Count up by one, holding at the frame limit.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < MAX_FRAME_PIXELS) ? v + CNT_W'(1) : MAX_FRAME_PIXELS;
   endfunction

endpackage

[rtl/core/mtb_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered (read-old).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read in the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/mtb_front.sv]
// ----------------------------------------------------------------------------
// Median threshold binarizer front end
// Accepts pixel items, computes the grey level and pushes a queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtb_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [7:0]                req_blue,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_red,
   input  logic                      req_frame_end,
   input  mtb_pkg::queue_status_type q_status,
   output logic                      q_push,
   output mtb_pkg::queue_entry_type  q_entry
);
   import mtb_pkg::*;

   logic [SUM_W-1:0]  chan_sum;
   logic [PROD_W-1:0] div_prod;

   // Grey level is the truncated mean of the three channels.
   assign chan_sum = SUM_W'(req_blue) + SUM_W'(req_green) + SUM_W'(req_red);
   assign div_prod = PROD_W'(chan_sum) * PROD_W'(DIV3_MUL);

   // Take an item whenever the queue has room.
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_entry.op        = req_op;
      q_entry.grey      = div_prod[DIV3_SHIFT +: BIN_W];
      q_entry.frame_end = req_frame_end;
   end

endmodule

[rtl/core/mtb_queue.sv]
// ----------------------------------------------------------------------------
// Median threshold binarizer item queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_push,
   input  mtb_pkg::queue_entry_type  q_entry,
   input  logic                      q_pop,
   output mtb_pkg::queue_status_type q_status,
   output mtb_pkg::queue_entry_type  q_head
);
   import mtb_pkg::*;

   queue_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!q_push && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_entry;
      end
   end

   assign q_head         = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

[rtl/core/mtb_back.sv]
// ----------------------------------------------------------------------------
// Median threshold binarizer back end
// Updates the histogram, scans it for the median at frame end, classifies
// pixels and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mtb_pkg::queue_status_type q_status,
   input  mtb_pkg::queue_entry_type  q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic [7:0]                rsp_grey_level,
   output logic [7:0]                rsp_binary_pixel,
   output logic [8:0]                rsp_threshold_value
);
   import mtb_pkg::*;

   back_state_type      state_ff;
   back_state_type      state_in;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   queue_entry_type     s1_entry_ff;
   queue_entry_type     s1_entry_in;

   logic [GREY_BINS-1:0] bin_valid_ff;
   logic [GREY_BINS-1:0] bin_valid_in;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     total_in;

   logic                fwd_valid_ff;
   logic                fwd_valid_in;
   logic [BIN_W-1:0]    fwd_addr_ff;
   logic [BIN_W-1:0]    fwd_addr_in;
   logic [CNT_W-1:0]    fwd_data_ff;
   logic [CNT_W-1:0]    fwd_data_in;

   logic [BIN_W-1:0]    rd_addr_ff;
   logic [THR_W-1:0]    walked_ff;
   logic [THR_W-1:0]    walked_in;
   logic [RUN_W-1:0]    run_ff;
   logic [RUN_W-1:0]    run_in;
   logic [THR_W-1:0]    threshold_ff;
   logic [THR_W-1:0]    threshold_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_kind_ff;
   logic                rsp_kind_in;
   logic [PIX_W-1:0]    rsp_grey_ff;
   logic [PIX_W-1:0]    rsp_grey_in;
   logic [PIX_W-1:0]    rsp_binary_ff;
   logic [PIX_W-1:0]    rsp_binary_in;
   logic [THR_W-1:0]    rsp_thr_ff;
   logic [THR_W-1:0]    rsp_thr_in;

   logic                ram_wr_en;
   logic [BIN_W-1:0]    ram_rd_addr;
   logic [CNT_W-1:0]    ram_rd_data;

   logic                slot_free;
   logic                s1_accum;
   logic                s1_class;
   logic                s1_done;
   logic                s1_last;
   logic [CNT_W-1:0]    bin_old;
   logic [CNT_W-1:0]    bin_new;
   logic [CNT_W-1:0]    half_total;
   logic                scan_done;
   logic                load_pixel;
   logic                load_report;

   // Histogram storage.
   mtb_ram #(
      .WIDTH (CNT_W),
      .DEPTH (GREY_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_entry_ff.grey),
      .wr_data (bin_new),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Stage status and the bin value with forwarding from the last write.
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      s1_accum  = s1_valid_ff && (s1_entry_ff.op == OP_ACCUM);
      s1_class  = s1_valid_ff && (s1_entry_ff.op == OP_CLASSIFY);
      s1_done   = s1_accum || (s1_class && slot_free);
      s1_last   = s1_accum && s1_entry_ff.frame_end;
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         bin_old = fwd_data_ff;
      end else if (bin_valid_ff[rd_addr_ff]) begin
         bin_old = ram_rd_data;
      end else begin
         bin_old = '0;
      end
      bin_new    = sat_inc(bin_old);
      half_total = total_ff >> 1;
      scan_done  = (run_ff >= RUN_W'(half_total)) || (walked_ff == THR_W'(GREY_BINS));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (s1_last) begin
               state_in = BK_SCAN_START;
            end
         end
         BK_SCAN_START: begin
            state_in = BK_SCAN;
         end
         BK_SCAN: begin
            if (scan_done) begin
               state_in = BK_REPORT;
            end
         end
         BK_REPORT: begin
            if (slot_free) begin
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // State outputs: queue pop, histogram write and read address, result loads.
   always_comb begin
      q_pop       = 1'b0;
      ram_wr_en   = 1'b0;
      load_pixel  = 1'b0;
      load_report = 1'b0;
      walked_in   = walked_ff;
      unique case (state_ff)
         BK_RUN: begin
            q_pop      = !q_status.empty && (!s1_valid_ff || s1_done) && !s1_last;
            ram_wr_en  = s1_accum;
            load_pixel = s1_class && slot_free;
         end
         BK_SCAN_START: begin
            walked_in = '0;
         end
         BK_SCAN: begin
            if (!scan_done) begin
               walked_in = walked_ff + THR_W'(1);
            end
         end
         BK_REPORT: begin
            load_report = slot_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      ram_rd_addr = (state_ff == BK_RUN) ? q_head.grey : walked_in[BIN_W-1:0];
   end

   // Datapath next values.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_entry_in  = q_pop ? q_head : s1_entry_ff;
      bin_valid_in = bin_valid_ff;
      total_in     = total_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      run_in       = run_ff;
      threshold_in = threshold_ff;

      // Stage occupancy.
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if ((state_ff == BK_RUN) && s1_done) begin
         s1_valid_in = 1'b0;
      end

      // Histogram and pixel count update.
      if (ram_wr_en) begin
         bin_valid_in[s1_entry_ff.grey] = 1'b1;
         total_in     = sat_inc(total_ff);
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s1_entry_ff.grey;
         fwd_data_in  = bin_new;
      end

      // Median scan accumulation.
      if (state_ff == BK_SCAN_START) begin
         run_in = '0;
      end else if (state_ff == BK_SCAN) begin
         if (scan_done) begin
            threshold_in = walked_ff;
         end else begin
            run_in = run_ff + RUN_W'(bin_old);
         end
      end

      // The report clears the histogram and the count at once.
      if (load_report) begin
         bin_valid_in = '0;
         total_in     = '0;
         fwd_valid_in = 1'b0;
      end
   end

   // Result register next values.
   always_comb begin
      rsp_kind_in   = rsp_kind_ff;
      rsp_grey_in   = rsp_grey_ff;
      rsp_binary_in = rsp_binary_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (load_pixel) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_PIXEL;
         rsp_grey_in   = s1_entry_ff.grey;
         rsp_binary_in = (THR_W'(s1_entry_ff.grey) > threshold_ff) ? WHITE_LEVEL : BLACK_LEVEL;
         rsp_thr_in    = threshold_ff;
      end else if (load_report) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_REPORT;
         rsp_grey_in   = s1_entry_ff.grey;
         rsp_binary_in = BLACK_LEVEL;
         rsp_thr_in    = threshold_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         s1_valid_ff  <= 1'b0;
         bin_valid_ff <= '0;
         total_ff     <= '0;
         fwd_valid_ff <= 1'b0;
         threshold_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         bin_valid_ff <= bin_valid_in;
         total_ff     <= total_in;
         fwd_valid_ff <= fwd_valid_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_addr_ff   <= ram_rd_addr;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_entry_ff   <= s1_entry_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_data_ff   <= fwd_data_in;
      walked_ff     <= walked_in;
      run_ff        <= run_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_grey_ff   <= rsp_grey_in;
      rsp_binary_ff <= rsp_binary_in;
      rsp_thr_ff    <= rsp_thr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_grey_level      = rsp_grey_ff;
   assign rsp_binary_pixel    = rsp_binary_ff;
   assign rsp_threshold_value = rsp_thr_ff;

endmodule

[rtl/core/median_threshold_binarizer.sv]
// ----------------------------------------------------------------------------
// Median threshold binarizer
// Builds a grey histogram per frame, finds the median threshold at frame end
// and binarizes pixels against it.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Fields
//   req       in          req_valid/req_ready    op, blue, green, red, frame_end
//   rsp       out         rsp_valid/rsp_ready    kind, grey_level, binary_pixel,
//                                                threshold_value
//
// Accumulate and classify items flow at one item per cycle through the
// histogram RAM unless the queue is empty or the back end is held; the back
// end forwards the last written bin to the next update. A frame-end item holds
// the back end in its scan and report states, the scan reading one bin per
// cycle from the RAM's single read port. Reset clears the bin valid bits at
// once, so no clearing pass is needed. A stalled result register stops
// classify items; the four-entry queue keeps taking items until it fills.
`timescale 1ns / 1ps

module median_threshold_binarizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_green,
   input  logic [7:0] req_red,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_grey_level,
   output logic [7:0] rsp_binary_pixel,
   output logic [8:0] rsp_threshold_value
);
   import mtb_pkg::*;

   queue_status_type q_status;
   queue_entry_type  q_entry;
   queue_entry_type  q_head;
   logic             q_push;
   logic             q_pop;

   // Grey level and item intake.
   mtb_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_blue      (req_blue),
      .req_green     (req_green),
      .req_red       (req_red),
      .req_frame_end (req_frame_end),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   // Decoupling queue.
   mtb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   // Histogram, scan and classification.
   mtb_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_grey_level      (rsp_grey_level),
      .rsp_binary_pixel    (rsp_binary_pixel),
      .rsp_threshold_value (rsp_threshold_value)
   );

endmodule

[rtl/core/mtb_checker.sv]
// ----------------------------------------------------------------------------
// Median threshold binarizer port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "median_threshold_binarizer_assert.svh"

module mtb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_grey_level,
   input logic [7:0] rsp_binary_pixel,
   input logic [8:0] rsp_threshold_value
);
   import mtb_pkg::*;

   logic report_ok;
   logic pixel_ok;

   // A report is black with a threshold no higher than the bin count, and a
   // classified pixel is white exactly when its grey level is above the threshold.
   always_comb begin
      report_ok = (rsp_binary_pixel == BLACK_LEVEL) &&
                  (rsp_threshold_value <= 9'(GREY_BINS));
      pixel_ok  = ((rsp_binary_pixel == WHITE_LEVEL) &&
                   ({1'b0, rsp_grey_level} > rsp_threshold_value)) ||
                  ((rsp_binary_pixel == BLACK_LEVEL) &&
                   ({1'b0, rsp_grey_level} <= rsp_threshold_value));
   end

   // No result is offered right after reset.
   `MTB_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // A result that is not taken stays offered.
   `MTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

   // A threshold report carries a black pixel and a threshold of at most 256.
   `MTB_ASSERT_IMPLY(a_report_form, clock, reset, rsp_valid && (rsp_kind == KIND_REPORT), report_ok, "bad report")

   // A classified pixel is white exactly when its grey level is above the threshold.
   `MTB_ASSERT_IMPLY(a_pixel_class, clock, reset, rsp_valid && (rsp_kind == KIND_PIXEL), pixel_ok, "bad pixel")

endmodule

bind median_threshold_binarizer mtb_checker u_checker (.*);
